FILE: rtl/three_class_priority_queue_with_pause_top_assert.svh
`ifndef THREE_CLASS_PRIORITY_QUEUE_WITH_PAUSE_TOP_ASSERT_SVH
`define THREE_CLASS_PRIORITY_QUEUE_WITH_PAUSE_TOP_ASSERT_SVH
// Assertion helpers shared by the queue RTL.
`define TCPQ_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("check failed");
`define TCPQ_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("check failed");
`endif

FILE: rtl/tcpq_pkg.sv
`timescale 1ns / 1ps
package tcpq_pkg;
  localparam int NUM_CLASSES = 3;
  localparam logic [1:0] CMD_ARRIVE = 2'd0;
  localparam logic [1:0] CMD_PAUSE = 2'd1;
  localparam logic [1:0] CMD_DONE = 2'd2;
  localparam logic [1:0] ST_READY = 2'd0;
  localparam logic [1:0] ST_PAUSE_RECEIVED = 2'd1;
  localparam logic [1:0] ST_PAUSED = 2'd2;
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_KIND = 2'd1;
  localparam logic [1:0] ERR_FULL = 2'd2;
  localparam logic [1:0] ERR_IDLE = 2'd3;
  localparam logic [1:0] CLS_LOW = 2'd0;
  localparam logic [1:0] CLS_MID = 2'd1;
  localparam logic [1:0] CLS_HIGH = 2'd2;
  localparam logic [1:0] CLS_NONE = 2'd3;
  localparam logic [3:0] KIND_LOW_MAX = 4'd2;
  localparam logic [3:0] KIND_CTRL_MAX = 4'd9;
  localparam logic [3:0] KIND_DATA = 4'd10;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_MUL = 4'b0100,
    S_OUT = 4'b1000
  } fsm_t;
endpackage

FILE: rtl/tcpq_store.sv
`timescale 1ns / 1ps
module tcpq_store import tcpq_pkg::*; #(
  parameter int AW = 8,
  parameter int DW = 30
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [NUM_CLASSES * (2 ** (AW - 2))];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/three_class_priority_queue_with_pause_top.sv
`timescale 1ns / 1ps
// Strict-priority three-class output queue with pause flow control.
// Input channel (valid/stall): one beat is a packet arrival, a pause
// frame or a link-done event. Output channel (valid/stall): exactly one
// result beat per input beat, with departure, service start, send state,
// queued byte total and error code.
// Config: cfg_we writes picoseconds_per_byte (reset 800); the user must
// write it only while idle, the block itself does not enforce it. One item
// is in work at a time; a new beat is taken only in the cycle after the
// result beat leaves. Each item passes two descriptor memory reads in turn
// (departing head, then the head that starts service), the drain-time
// multiply and the result register.
// Reset (rst, synchronous): all class queues empty, state ready, no
// packet in service, no result pending. The descriptor memory is not
// cleared; entries are read only after they are written.
// While the receiver stalls, the result holds and no new beat is taken.
module three_class_priority_queue_with_pause_top import tcpq_pkg::*; #(
  parameter int CLASS_DEPTH = 64,
  parameter int TAG_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [3:0]  packet_kind,
  input  logic        trimmed,
  input  logic        retransmitted,
  input  logic [13:0] packet_bytes,
  input  logic [15:0] packet_tag,
  input  logic [15:0] pause_time,
  input  logic        cfg_we,
  input  logic [23:0] cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        departed_valid,
  output logic [15:0] departed_tag,
  output logic        started_valid,
  output logic [15:0] started_tag,
  output logic [1:0]  started_class,
  output logic [37:0] drain_time_ps,
  output logic [1:0]  send_state,
  output logic [21:0] queued_bytes,
  output logic [1:0]  error_code
);
  `include "three_class_priority_queue_with_pause_top_assert.svh"

  localparam int PW = (CLASS_DEPTH > 1) ? $clog2(CLASS_DEPTH) : 1;
  localparam int CW = $clog2(CLASS_DEPTH + 1);
  localparam int AW = PW + 2;
  localparam int DW = TAG_BITS + 14;
  localparam int BW = CW + 14;

  fsm_t state;
  logic [23:0] ps_per_byte;
  logic [PW-1:0] head [NUM_CLASSES];
  logic [PW-1:0] tail [NUM_CLASSES];
  logic [CW-1:0] count [NUM_CLASSES];
  logic [BW-1:0] bcount [NUM_CLASSES];
  logic [1:0] pstate;
  logic [1:0] serving;
  logic in_service;

  logic [1:0] cls_r;
  logic start_r, depart_r;
  logic [1:0] st_cls;
  logic [13:0] st_bytes;
  logic [TAG_BITS-1:0] st_tag;

  logic mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [DW-1:0] mem_wdata, mem_rdata;

  tcpq_store #(.AW(AW), .DW(DW)) u_store (
    .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(mem_raddr), .rdata(mem_rdata)
  );

  logic accept;
  assign in_stall = (state != S_IDLE) || out_valid;
  assign accept = in_valid && !in_stall;

  logic [1:0] in_cls;
  always_comb begin
    if (packet_kind <= KIND_LOW_MAX) begin
      in_cls = CLS_LOW;
    end else if (packet_kind <= KIND_CTRL_MAX) begin
      in_cls = CLS_HIGH;
    end else if (trimmed) begin
      in_cls = CLS_HIGH;
    end else if (retransmitted) begin
      in_cls = CLS_MID;
    end else begin
      in_cls = CLS_LOW;
    end
  end

  function automatic logic [AW-1:0] addr_of(input logic [1:0] c, input logic [PW-1:0] p);
    return {c, p};
  endfunction

  function automatic logic [PW-1:0] nxt(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    r = (32'(p) + 32'd1 >= 32'(CLASS_DEPTH)) ? '0 : PW'(32'(p) + 32'd1);
    return r;
  endfunction

  // Apply the command to the queue state at accept; pick the class to start.
  logic [1:0] pick;
  logic any_q;
  logic [CW-1:0] cnt_n [NUM_CLASSES];
  logic [PW-1:0] tail_n [NUM_CLASSES];
  logic [PW-1:0] head_n [NUM_CLASSES];
  logic [BW-1:0] bc_n [NUM_CLASSES];
  logic [1:0] pstate_next, serving_next, err_next;
  logic in_service_next, want_start, depart_next;

  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      cnt_n[c] = count[c];
      tail_n[c] = tail[c];
      head_n[c] = head[c];
      bc_n[c] = bcount[c];
    end
    pstate_next = pstate;
    serving_next = serving;
    in_service_next = in_service;
    err_next = ERR_NONE;
    want_start = 1'b0;
    depart_next = 1'b0;
    mem_we = 1'b0;
    mem_waddr = addr_of(in_cls, tail[in_cls]);
    mem_wdata = {TAG_BITS'(packet_tag), packet_bytes};
    case (command)
      CMD_ARRIVE: begin
        if (packet_kind > KIND_DATA) begin
          err_next = ERR_KIND;
        end else if (32'(count[in_cls]) >= 32'(CLASS_DEPTH)) begin
          err_next = ERR_FULL;
        end else begin
          mem_we = accept;
          tail_n[in_cls] = nxt(tail[in_cls]);
          cnt_n[in_cls] = count[in_cls] + 1'b1;
          bc_n[in_cls] = bcount[in_cls] + BW'(packet_bytes);
          want_start = !in_service && pstate == ST_READY;
        end
      end
      CMD_PAUSE: begin
        if (pause_time != 16'd0) begin
          pstate_next = in_service ? ST_PAUSE_RECEIVED : ST_PAUSED;
        end else begin
          pstate_next = ST_READY;
          want_start = !in_service;
        end
      end
      CMD_DONE: begin
        if (!in_service || serving == CLS_NONE || count[serving] == '0) begin
          err_next = ERR_IDLE;
        end else begin
          depart_next = 1'b1;
          cnt_n[serving] = count[serving] - 1'b1;
          head_n[serving] = nxt(head[serving]);
          in_service_next = 1'b0;
          serving_next = CLS_NONE;
          if (pstate == ST_PAUSE_RECEIVED) begin
            pstate_next = ST_PAUSED;
          end
          want_start = (pstate == ST_READY);
        end
      end
      default: begin
      end
    endcase
    any_q = 1'b1;
    if (cnt_n[2] != '0) begin
      pick = CLS_HIGH;
    end else if (cnt_n[1] != '0) begin
      pick = CLS_MID;
    end else if (cnt_n[0] != '0) begin
      pick = CLS_LOW;
    end else begin
      pick = CLS_NONE;
      any_q = 1'b0;
    end
    if (want_start && any_q) begin
      in_service_next = 1'b1;
      serving_next = pick;
    end else begin
      want_start = 1'b0;
    end
  end

  assign mem_raddr = (state == S_IDLE) ? addr_of(serving, head[serving])
                                       : addr_of(st_cls, head[st_cls]);

  logic [DW-1:0] dep_word;
  logic [37:0] prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ps_per_byte <= 24'd800;
      pstate <= ST_READY;
      serving <= CLS_NONE;
      in_service <= 1'b0;
      out_valid <= 1'b0;
      for (int c = 0; c < NUM_CLASSES; c++) begin
        head[c] <= '0;
        tail[c] <= '0;
        count[c] <= '0;
        bcount[c] <= '0;
      end
    end else begin
      if (cfg_we) begin
        ps_per_byte <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_READ;
            for (int c = 0; c < NUM_CLASSES; c++) begin
              count[c] <= cnt_n[c];
              tail[c] <= tail_n[c];
              head[c] <= head_n[c];
              bcount[c] <= bc_n[c];
            end
            pstate <= pstate_next;
            serving <= serving_next;
            in_service <= in_service_next;
          end
        end
        S_READ: begin
          // head word of the departing class is on mem_rdata
          state <= S_MUL;
          if (depart_r) begin
            bcount[cls_r] <= bcount[cls_r] - BW'(mem_rdata[13:0]);
          end
        end
        S_MUL: begin
          state <= S_OUT;
        end
        S_OUT: begin
          state <= S_IDLE;
          out_valid <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload path.
  always_ff @(posedge clk) begin
    if (accept) begin
      cls_r <= serving;
      depart_r <= depart_next;
      start_r <= want_start;
      st_cls <= serving_next;
      error_code <= err_next;
    end
    if (state == S_READ) begin
      dep_word <= mem_rdata;
    end
    if (state == S_MUL) begin
      // start read issued in S_READ (head already advanced if same class)
      st_tag <= mem_rdata[DW-1:14];
      st_bytes <= mem_rdata[13:0];
    end
    if (state == S_OUT) begin
      departed_valid <= depart_r;
      departed_tag <= depart_r ? 16'(dep_word[DW-1:14]) : 16'd0;
      started_valid <= start_r;
      started_tag <= start_r ? 16'(st_tag) : 16'd0;
      started_class <= start_r ? st_cls : 2'd0;
      drain_time_ps <= start_r ? prod : 38'd0;
      send_state <= pstate;
      queued_bytes <= 22'(32'(bcount[0]) + 32'(bcount[1]) + 32'(bcount[2]));
    end
  end

  assign prod = 38'(st_bytes) * 38'(ps_per_byte);

  `TCPQ_ASSERT_IMP(a_stall_busy, clk, rst, state != S_IDLE, in_stall)
  `TCPQ_ASSERT_NEXT(a_acc_read, clk, rst, accept, state == S_READ)
  `TCPQ_ASSERT_IMP(a_serv_cls, clk, rst, in_service, serving != CLS_NONE)
  `TCPQ_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
endmodule

FILE: verif/three_class_priority_queue_with_pause_top_tb.sv
`timescale 1ns / 1ps
module three_class_priority_queue_with_pause_top_tb;
  import tcpq_pkg::*;

  localparam int DEPTH = 64;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [3:0]  kind;
    logic        hdr;
    logic        rtx;
    logic [13:0] nbytes;
    logic [15:0] tag;
    logic [15:0] ptime;
  } port_event_t;

  typedef struct packed {
    logic        dep_v;
    logic [15:0] dep_tag;
    logic        st_v;
    logic [15:0] st_tag;
    logic [1:0]  st_cls;
    logic [37:0] drain;
    logic [1:0]  sstate;
    logic [21:0] qbytes;
    logic [1:0]  err;
  } port_status_t;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_stall;
  logic [1:0]  command = 0;
  logic [3:0]  packet_kind = 0;
  logic        trimmed = 0;
  logic        retransmitted = 0;
  logic [13:0] packet_bytes = 0;
  logic [15:0] packet_tag = 0;
  logic [15:0] pause_time = 0;
  logic        cfg_we = 0;
  logic [23:0] cfg_data = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic        departed_valid;
  logic [15:0] departed_tag;
  logic        started_valid;
  logic [15:0] started_tag;
  logic [1:0]  started_class;
  logic [37:0] drain_time_ps;
  logic [1:0]  send_state;
  logic [21:0] queued_bytes;
  logic [1:0]  error_code;

  three_class_priority_queue_with_pause_top dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .packet_kind(packet_kind), .trimmed(trimmed),
    .retransmitted(retransmitted), .packet_bytes(packet_bytes),
    .packet_tag(packet_tag), .pause_time(pause_time),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .departed_valid(departed_valid), .departed_tag(departed_tag),
    .started_valid(started_valid), .started_tag(started_tag),
    .started_class(started_class), .drain_time_ps(drain_time_ps),
    .send_state(send_state), .queued_bytes(queued_bytes),
    .error_code(error_code)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // port queue shadow state
  logic [15:0] q_tag [3][DEPTH];
  logic [13:0] q_bytes [3][DEPTH];
  int          q_head [3];
  int          q_tail [3];
  int          q_count [3];
  longint      q_sum [3];
  logic [1:0]  pstate = ST_READY;
  logic [1:0]  serving = CLS_NONE;
  bit          busy = 0;
  logic [23:0] ps_per_byte = 24'd800;

  port_event_t  pending_events [$];
  port_status_t expected_status [$];
  int mismatches = 0;
  int idle_max = 16;
  int cycles = 0;

  function automatic void begin_service(inout port_status_t r);
    for (int c = 2; c >= 0; c--) begin
      if (q_count[c] > 0) begin
        serving = c[1:0];
        busy = 1;
        r.st_v = 1;
        r.st_tag = q_tag[c][q_head[c]];
        r.st_cls = c[1:0];
        r.drain = 38'(q_bytes[c][q_head[c]]) * 38'(ps_per_byte);
        return;
      end
    end
  endfunction

  function automatic port_status_t apply_event(port_event_t e);
    port_status_t r;
    logic [1:0] cls;
    int c;
    r = '0;
    case (e.cmd)
      CMD_ARRIVE: begin
        if (e.kind > KIND_DATA) begin
          r.err = ERR_KIND;
        end else begin
          if (e.kind <= KIND_LOW_MAX) cls = CLS_LOW;
          else if (e.kind <= KIND_CTRL_MAX) cls = CLS_HIGH;
          else cls = e.hdr ? CLS_HIGH : (e.rtx ? CLS_MID : CLS_LOW);
          if (q_count[cls] >= DEPTH) begin
            r.err = ERR_FULL;
          end else begin
            q_tag[cls][q_tail[cls]] = e.tag;
            q_bytes[cls][q_tail[cls]] = e.nbytes;
            q_tail[cls] = (q_tail[cls] + 1) % DEPTH;
            q_count[cls]++;
            q_sum[cls] += e.nbytes;
            if (!busy && pstate == ST_READY) begin_service(r);
          end
        end
      end
      CMD_PAUSE: begin
        if (e.ptime != 0) begin
          pstate = busy ? ST_PAUSE_RECEIVED : ST_PAUSED;
        end else begin
          pstate = ST_READY;
          if (!busy) begin_service(r);
        end
      end
      CMD_DONE: begin
        c = serving;
        if (!busy || serving == CLS_NONE || q_count[c] == 0) begin
          r.err = ERR_IDLE;
        end else begin
          r.dep_v = 1;
          r.dep_tag = q_tag[c][q_head[c]];
          q_sum[c] -= q_bytes[c][q_head[c]];
          q_count[c]--;
          q_head[c] = (q_head[c] + 1) % DEPTH;
          busy = 0;
          serving = CLS_NONE;
          if (pstate == ST_PAUSE_RECEIVED) pstate = ST_PAUSED;
          if (pstate == ST_READY) begin_service(r);
        end
      end
      default: ;
    endcase
    r.sstate = pstate;
    r.qbytes = 22'(q_sum[0] + q_sum[1] + q_sum[2]);
    return r;
  endfunction

  // driver
  int send_gap = 0;
  always @(posedge clk) begin
    port_event_t e;
    bit take;
    if (!rst) begin
      take = in_valid && !in_stall;
      if (take) begin
        expected_status.push_back(apply_event({command, packet_kind, trimmed,
            retransmitted, packet_bytes, packet_tag, pause_time}));
        send_gap <= $urandom_range(0, idle_max);
      end
      if (!in_valid || take) begin
        if ((take ? 0 : send_gap) == 0 && pending_events.size() > 0 &&
            !(take && idle_max > 0)) begin
          e = pending_events.pop_front();
          {command, packet_kind, trimmed, retransmitted, packet_bytes,
           packet_tag, pause_time} <= e;
          in_valid <= 1;
        end else begin
          in_valid <= 0;
          if (!take && send_gap > 0) send_gap <= send_gap - 1;
        end
      end
    end
  end

  // monitor
  int recv_wait = 0;
  always @(posedge clk) begin
    port_status_t got, want;
    int n;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got = {departed_valid, departed_tag, started_valid, started_tag,
               started_class, drain_time_ps, send_state, queued_bytes, error_code};
        if (expected_status.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected beat %h", got);
        end else begin
          want = expected_status.pop_front();
          if (got !== want) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10) $display("mismatch exp %h got %h", want, got);
          end
        end
        n = $urandom_range(0, idle_max);
        recv_wait <= n;
        out_stall <= (n != 0);
      end else if (recv_wait > 0) begin
        recv_wait <= recv_wait - 1;
        out_stall <= (recv_wait > 1);
      end else begin
        out_stall <= 0;
      end
    end
  end

  function automatic port_event_t mk(logic [1:0] cmd, logic [3:0] kind, bit hdr,
                                     bit rtx, logic [13:0] nb, logic [15:0] tag,
                                     logic [15:0] pt);
    return {cmd, kind, hdr, rtx, nb, tag, pt};
  endfunction

  function automatic port_event_t rand_event();
    int w;
    port_event_t e;
    e = {2'($urandom_range(0, 3)), 4'($urandom_range(0, 10)), 1'($urandom),
         1'($urandom), 14'($urandom_range(1, 16383)), 16'($urandom), 16'($urandom)};
    w = $urandom_range(0, 99);
    if (w < 48) e.cmd = CMD_ARRIVE;
    else if (w < 88) e.cmd = CMD_DONE;
    else if (w < 97) e.cmd = CMD_PAUSE;
    else e.cmd = 2'd3;
    if (e.cmd == CMD_PAUSE && $urandom_range(0, 1)) e.ptime = 0;
    if ($urandom_range(0, 30) == 0) e.kind = 4'($urandom_range(11, 15));
    if ($urandom_range(0, 10) == 0) e.nbytes = $urandom_range(0, 1) ? 14'd1 : 14'd16383;
    return e;
  endfunction

  task automatic settle();
    while (pending_events.size() > 0 || in_valid || expected_status.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_rate(logic [23:0] v);
    settle();
    cfg_we <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    ps_per_byte = v;
  endtask

  initial begin
    for (int c = 0; c < 3; c++) begin
      q_head[c] = 0; q_tail[c] = 0; q_count[c] = 0; q_sum[c] = 0;
    end
    repeat (2) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    pending_events.push_back(mk(CMD_DONE, 0, 0, 0, 5, 1, 0));
    pending_events.push_back(mk(2'd3, 0, 0, 0, 5, 2, 0));
    pending_events.push_back(mk(CMD_ARRIVE, 15, 1, 1, 5, 3, 0));
    pending_events.push_back(mk(CMD_ARRIVE, 0, 0, 0, 1, 16'h0000, 0));
    pending_events.push_back(mk(CMD_ARRIVE, 3, 0, 0, 16383, 16'hffff, 0));
    pending_events.push_back(mk(CMD_ARRIVE, 10, 1, 1, 100, 10, 0));
    pending_events.push_back(mk(CMD_ARRIVE, 10, 0, 1, 200, 11, 0));
    pending_events.push_back(mk(CMD_ARRIVE, 10, 0, 0, 300, 12, 0));
    pending_events.push_back(mk(CMD_ARRIVE, 9, 0, 0, 400, 13, 0));
    pending_events.push_back(mk(CMD_ARRIVE, 2, 1, 1, 500, 14, 0));
    pending_events.push_back(mk(CMD_PAUSE, 0, 0, 0, 1, 0, 16'hffff));
    pending_events.push_back(mk(CMD_PAUSE, 0, 0, 0, 1, 0, 16'h0001));
    pending_events.push_back(mk(CMD_DONE, 0, 0, 0, 1, 0, 0));
    pending_events.push_back(mk(CMD_DONE, 0, 0, 0, 1, 0, 0));
    pending_events.push_back(mk(CMD_PAUSE, 0, 0, 0, 1, 0, 0));
    pending_events.push_back(mk(CMD_PAUSE, 0, 0, 0, 1, 0, 7));
    pending_events.push_back(mk(CMD_PAUSE, 0, 0, 0, 1, 0, 0));
    for (int i = 0; i < 7; i++) pending_events.push_back(mk(CMD_DONE, 0, 0, 0, 1, 0, 0));
    pending_events.push_back(mk(CMD_PAUSE, 0, 0, 0, 1, 0, 3));
    settle();

    // fill one class past its depth while paused, then drain
    write_rate(24'd1);
    for (int i = 0; i < DEPTH + 3; i++)
      pending_events.push_back(mk(CMD_ARRIVE, 10, 1, 0,
                                  14'($urandom_range(1, 16383)), 16'($urandom), 0));
    pending_events.push_back(mk(CMD_PAUSE, 0, 0, 0, 1, 0, 0));
    for (int i = 0; i < DEPTH + 2; i++) pending_events.push_back(mk(CMD_DONE, 0, 0, 0, 1, 0, 0));
    settle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: write_rate(24'hffffff);
        1: write_rate(24'($urandom_range(1, 24'hffffff)));
        2: write_rate(24'd800);
        default: write_rate(24'($urandom_range(1, 4096)));
      endcase
      idle_max = (ph == 2) ? 0 : 16;
      for (int i = 0; i < 248; i++) pending_events.push_back(rand_event());
    end
    idle_max = 16;
    settle();

    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
